### src/assert_macros.svh
// Assertion macros for the scoreboard datapath.
// Each macro checks a property on the rising edge of clk_i, masked while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger implies a condition on the same edge.
`define GDS_ASSERT_IMP(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

`endif

### src/gds_pkg.sv
// Package for the generation dependency scoreboard.
// Holds sizes, codes, the controller state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

package gds_pkg;

  localparam int MaxNodes     = 1024;
  localparam int MaxRelations = 4096;
  localparam int NodeW        = $clog2(MaxNodes);
  localparam int RelW         = $clog2(MaxRelations);
  localparam int NcntW        = 11;
  localparam int RcntW        = 13;
  localparam int DataW        = 13;
  localparam int GenW         = 32;
  localparam int EpochW       = 32;
  localparam int UnmetW       = 11;
  localparam int OffDepth     = MaxNodes + 1;
  localparam int OffAddrW     = $clog2(OffDepth);

  localparam logic [DataW-1:0] FailCode = '1;

  typedef enum logic [2:0] {
    OP_EXEC       = 3'd0,
    OP_RESET_RUN  = 3'd1,
    OP_ABORT      = 3'd2,
    OP_WR_OFFSET  = 3'd3,
    OP_WR_LAUNCH  = 3'd4,
    OP_PREP_CLEAR = 3'd5
  } op_e;

  typedef enum logic {
    REG_NODE_COUNT     = 1'b0,
    REG_RELATION_COUNT = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_DEC,
    S_CLEAR,
    S_OFF1,
    S_OFF2,
    S_EVAL,
    S_LL,
    S_GRD,
    S_GUPD,
    S_MCHK,
    S_MUPD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic op_apply;
    logic rd_start;
    logic rd_end;
    logic cap_end;
    logic free_wr;
    logic ll_rd;
    logic gen_rd_id;
    logic req_wr;
    logic unmet_inc;
    logic unmet_dec;
    logic i_inc;
    logic gen_rd_n;
    logic sub_wr;
    logic fail;
    logic st_abort;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic aborted;
    logic free_max;
    logic walk_last;
    logic skip;
    logic need_count;
    logic unmet_full;
    logic member_ok;
    logic sub_max;
    logic uncount;
    logic unmet_zero;
    logic clr_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### src/generation_dependency_scoreboard.sv
// Sequence from accept to result load: table, abort and no-op words go straight to the result;
// reset-run and prepare-clear first run a 1024-entry clearing sweep; node-executed words fetch
// both offsets, walk the launch list entry by entry unless aborted, and may then update the member.
// Throughput: one word at a time, the next accepted in the cycle after the result loads; the
// launch walk sets it, and a stalled result word holds the block until it is taken.
// Reset: async low; a 1024-entry clearing sweep with in_ready_o low; config taken any time.
`timescale 1ns / 1ps
`default_nettype none

module generation_dependency_scoreboard (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [2:0]                       opcode_i,
  input  wire  [gds_pkg::NodeW-1:0]        node_i,
  input  wire  [gds_pkg::RcntW-1:0]        slot_i,
  input  wire  [gds_pkg::DataW-1:0]        value_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [gds_pkg::DataW-1:0]        status_o,
  output logic [gds_pkg::UnmetW-1:0]       unmet_count_o,
  output logic                             all_met_o,
  output logic                             aborted_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire                              cfg_index_i,
  input  wire  [gds_pkg::DataW-1:0]        cfg_data_i
);

  gds_pkg::dp_cmd_t    cmd;
  gds_pkg::dp_status_t dp_status;

  // Register writes are registered directly, so the port never stalls.
  assign cfg_ready_o = 1'b1;

  // Sequence each word: decode, offset fetch, launch walk, member update, result.
  gds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // Hold the tables, generation memories, counters and the result word.
  gds_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .opcode_i      (opcode_i),
    .node_i        (node_i),
    .slot_i        (slot_i),
    .value_i       (value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_status_o (status_o),
    .unmet_count_o (unmet_count_o),
    .all_met_o     (all_met_o),
    .aborted_o     (aborted_o)
  );

endmodule

`default_nettype wire

### src/gds_ctrl.sv
// Controller state machine of the scoreboard.
// Uses gds_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module gds_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  gds_pkg::dp_status_t  status_i,
  output gds_pkg::dp_cmd_t     cmd_o
);

  gds_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gds_pkg::S_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gds_pkg::S_BOOT: begin
        if (status_i.clr_last) state_d = gds_pkg::S_IDLE;
      end
      gds_pkg::S_IDLE: begin
        if (in_valid_i) state_d = gds_pkg::S_DEC;
      end
      gds_pkg::S_DEC: begin
        case (status_i.op)
          gds_pkg::OP_EXEC: state_d = gds_pkg::S_OFF1;
          gds_pkg::OP_RESET_RUN,
          gds_pkg::OP_PREP_CLEAR: state_d = gds_pkg::S_CLEAR;
          default: state_d = gds_pkg::S_DONE;
        endcase
      end
      gds_pkg::S_CLEAR: begin
        if (status_i.clr_last) state_d = gds_pkg::S_DONE;
      end
      gds_pkg::S_OFF1: state_d = gds_pkg::S_OFF2;
      gds_pkg::S_OFF2: state_d = gds_pkg::S_EVAL;
      gds_pkg::S_EVAL: begin
        if (status_i.empty) state_d = gds_pkg::S_MCHK;
        else if (status_i.aborted || status_i.free_max) state_d = gds_pkg::S_DONE;
        else state_d = gds_pkg::S_LL;
      end
      gds_pkg::S_LL: state_d = gds_pkg::S_GRD;
      gds_pkg::S_GRD: state_d = gds_pkg::S_GUPD;
      gds_pkg::S_GUPD: begin
        if (!status_i.skip && status_i.need_count && status_i.unmet_full) begin
          state_d = gds_pkg::S_DONE;
        end else if (status_i.walk_last) begin
          state_d = gds_pkg::S_MCHK;
        end else begin
          state_d = gds_pkg::S_LL;
        end
      end
      gds_pkg::S_MCHK: begin
        if (!status_i.member_ok || status_i.aborted) state_d = gds_pkg::S_DONE;
        else state_d = gds_pkg::S_MUPD;
      end
      gds_pkg::S_MUPD: state_d = gds_pkg::S_DONE;
      gds_pkg::S_DONE: begin
        if (!status_i.out_busy) state_d = gds_pkg::S_IDLE;
      end
      default: state_d = gds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      gds_pkg::S_BOOT: cmd_o.clr_step = 1'b1;
      gds_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      gds_pkg::S_DEC: begin
        case (status_i.op)
          gds_pkg::OP_EXEC: cmd_o.rd_start = 1'b1;
          gds_pkg::OP_RESET_RUN,
          gds_pkg::OP_PREP_CLEAR: cmd_o.clr_start = 1'b1;
          default: cmd_o.op_apply = 1'b1;
        endcase
      end
      gds_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.op_apply = status_i.clr_last;
      end
      gds_pkg::S_OFF1: cmd_o.rd_end = 1'b1;
      gds_pkg::S_OFF2: cmd_o.cap_end = 1'b1;
      gds_pkg::S_EVAL: begin
        if (!status_i.empty) begin
          if (status_i.aborted) cmd_o.st_abort = 1'b1;
          else if (status_i.free_max) cmd_o.fail = 1'b1;
          else cmd_o.free_wr = 1'b1;
        end
      end
      gds_pkg::S_LL: cmd_o.ll_rd = 1'b1;
      gds_pkg::S_GRD: cmd_o.gen_rd_id = 1'b1;
      gds_pkg::S_GUPD: begin
        if (!status_i.skip) begin
          cmd_o.req_wr = 1'b1;
          if (status_i.need_count) begin
            if (status_i.unmet_full) cmd_o.fail = 1'b1;
            else cmd_o.unmet_inc = 1'b1;
          end
        end
        cmd_o.i_inc = 1'b1;
      end
      gds_pkg::S_MCHK: begin
        if (status_i.member_ok) begin
          if (status_i.aborted) cmd_o.st_abort = 1'b1;
          else cmd_o.gen_rd_n = 1'b1;
        end
      end
      gds_pkg::S_MUPD: begin
        if (status_i.sub_max) begin
          cmd_o.fail = 1'b1;
        end else begin
          cmd_o.sub_wr = 1'b1;
          if (status_i.uncount) begin
            if (status_i.unmet_zero) cmd_o.fail = 1'b1;
            else cmd_o.unmet_dec = 1'b1;
          end
        end
      end
      gds_pkg::S_DONE: cmd_o.load_result = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/gds_datapath.sv
// Datapath of the scoreboard: tables, generation memories, counters and result word.
// Uses gds_pkg; driven by commands from gds_ctrl; macros from assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gds_datapath (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  gds_pkg::dp_cmd_t                 cmd_i,
  output gds_pkg::dp_status_t              status_o,
  input  wire  [2:0]                       opcode_i,
  input  wire  [gds_pkg::NodeW-1:0]        node_i,
  input  wire  [gds_pkg::RcntW-1:0]        slot_i,
  input  wire  [gds_pkg::DataW-1:0]        value_i,
  input  wire                              cfg_valid_i,
  input  wire                              cfg_index_i,
  input  wire  [gds_pkg::DataW-1:0]        cfg_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [gds_pkg::DataW-1:0]        word_status_o,
  output logic [gds_pkg::UnmetW-1:0]       unmet_count_o,
  output logic                             all_met_o,
  output logic                             aborted_o
);

  localparam int NodeW  = gds_pkg::NodeW;
  localparam int RelW   = gds_pkg::RelW;
  localparam int GenW   = gds_pkg::GenW;
  localparam int DataW  = gds_pkg::DataW;
  localparam int RcntW  = gds_pkg::RcntW;
  localparam int NcntW  = gds_pkg::NcntW;
  localparam int UnmetW = gds_pkg::UnmetW;
  localparam int OffW   = gds_pkg::OffAddrW;
  localparam int EpochW = gds_pkg::EpochW;

  // memories
  logic [DataW-1:0] off_mem [gds_pkg::OffDepth];
  logic [NodeW:0]   ll_mem  [gds_pkg::MaxRelations];
  logic             mem_mem [gds_pkg::MaxNodes];
  logic [GenW-1:0]  free_mem [gds_pkg::MaxNodes];
  logic [GenW-1:0]  req_mem  [gds_pkg::MaxNodes];
  logic [GenW-1:0]  sub_mem  [gds_pkg::MaxNodes];

  // read data
  logic [DataW-1:0] off_rd_q;
  logic [NodeW:0]   ll_rd_q;
  logic             mem_rd_q;
  logic [GenW-1:0]  free_rd_q, req_rd_q, sub_rd_q;

  // item and control registers
  gds_pkg::op_e     op_q;
  logic [NodeW-1:0] n_q;
  logic [RcntW-1:0] slot_q;
  logic [DataW-1:0] val_q;
  logic [DataW-1:0] start_q, end_q, i_q;
  logic [NodeW-1:0] id_q;
  logic [GenW-1:0]  fg_q;
  logic [DataW-1:0] st_q;
  logic [NcntW-1:0] node_count_q;
  logic [RcntW-1:0] relation_count_q;
  logic [UnmetW-1:0] unmet_q;
  logic             abort_q;
  logic [DataW-1:0] code_q;
  logic [EpochW-1:0] epoch_q;
  logic [NodeW-1:0] clr_q;
  logic             clr_mem_q;
  logic             out_valid_q;

  logic [RcntW-1:0] rel_used, end_clamp;
  logic [NcntW-1:0] nodes_used;
  logic             node_in;
  logic [OffW-1:0]  off_raddr;
  logic [NodeW-1:0] gen_raddr;
  logic [GenW-1:0]  sub_inc;

  assign nodes_used = (node_count_q > NcntW'(gds_pkg::MaxNodes))
                      ? NcntW'(gds_pkg::MaxNodes) : node_count_q;
  assign rel_used   = (relation_count_q > RcntW'(gds_pkg::MaxRelations))
                      ? RcntW'(gds_pkg::MaxRelations) : relation_count_q;
  assign end_clamp  = (end_q > rel_used) ? rel_used : end_q;
  assign node_in    = {1'b0, n_q} < nodes_used;
  assign off_raddr  = cmd_i.rd_end ? (OffW'(n_q) + OffW'(1)) : OffW'(n_q);
  assign gen_raddr  = cmd_i.gen_rd_id ? ll_rd_q[NodeW-1:0] : n_q;
  assign sub_inc    = sub_rd_q + GenW'(1);

  // table writes and reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.op_apply && op_q == gds_pkg::OP_WR_OFFSET
        && slot_q <= RcntW'(gds_pkg::MaxNodes)) begin
      off_mem[slot_q[OffW-1:0]] <= val_q;
    end
    if (cmd_i.op_apply && op_q == gds_pkg::OP_WR_LAUNCH
        && slot_q < RcntW'(gds_pkg::MaxRelations)) begin
      ll_mem[slot_q[RelW-1:0]] <= {val_q >= DataW'(gds_pkg::MaxNodes), val_q[NodeW-1:0]};
    end
    if (cmd_i.rd_start || cmd_i.rd_end) off_rd_q <= off_mem[off_raddr];
    if (cmd_i.ll_rd) ll_rd_q <= ll_mem[i_q[RelW-1:0]];
  end

  // membership
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_mem_q) begin
      mem_mem[clr_q] <= 1'b0;
    end else if (cmd_i.op_apply && op_q == gds_pkg::OP_WR_LAUNCH
                 && slot_q < RcntW'(gds_pkg::MaxRelations)
                 && val_q < DataW'(gds_pkg::MaxNodes)) begin
      mem_mem[val_q[NodeW-1:0]] <= 1'b1;
    end
    if (cmd_i.rd_start) mem_rd_q <= mem_mem[n_q];
  end

  // generation memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) free_mem[clr_q] <= '0;
    else if (cmd_i.free_wr) free_mem[n_q] <= free_rd_q + GenW'(1);
    if (cmd_i.rd_start) free_rd_q <= free_mem[n_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) req_mem[clr_q] <= '0;
    else if (cmd_i.req_wr) req_mem[id_q] <= fg_q;
    if (cmd_i.gen_rd_id || cmd_i.gen_rd_n) req_rd_q <= req_mem[gen_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) sub_mem[clr_q] <= '0;
    else if (cmd_i.sub_wr) sub_mem[n_q] <= sub_inc;
    if (cmd_i.gen_rd_id || cmd_i.gen_rd_n) sub_rd_q <= sub_mem[gen_raddr];
  end

  // item word and walk state
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= gds_pkg::op_e'(opcode_i);
      n_q    <= node_i;
      slot_q <= slot_i;
      val_q  <= value_i;
    end
    if (cmd_i.rd_end) start_q <= off_rd_q;
    if (cmd_i.cap_end) end_q <= off_rd_q;
    if (cmd_i.free_wr) begin
      fg_q <= free_rd_q + GenW'(1);
      i_q  <= start_q;
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + DataW'(1);
    end
    if (cmd_i.gen_rd_id) id_q <= ll_rd_q[NodeW-1:0];
  end

  // configuration, counters and abort state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q     <= '0;
      relation_count_q <= '0;
      unmet_q          <= '0;
      abort_q          <= 1'b0;
      code_q           <= '0;
      epoch_q          <= '0;
      st_q             <= '0;
      clr_q            <= '0;
      clr_mem_q        <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        unique case (gds_pkg::reg_e'(cfg_index_i))
          gds_pkg::REG_NODE_COUNT:     node_count_q     <= cfg_data_i[NcntW-1:0];
          gds_pkg::REG_RELATION_COUNT: relation_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_start) begin
        clr_q     <= '0;
        clr_mem_q <= (op_q == gds_pkg::OP_PREP_CLEAR);
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + NodeW'(1);
      end
      if (cmd_i.accept) st_q <= '0;
      if (cmd_i.st_abort) st_q <= code_q;
      if (cmd_i.unmet_inc) unmet_q <= unmet_q + UnmetW'(1);
      if (cmd_i.unmet_dec) unmet_q <= unmet_q - UnmetW'(1);
      if (cmd_i.op_apply) begin
        case (op_q)
          gds_pkg::OP_RESET_RUN: begin
            unmet_q <= '0;
            if (epoch_q == '1) begin
              abort_q <= 1'b1;
              code_q  <= gds_pkg::FailCode;
            end else begin
              abort_q <= 1'b0;
              code_q  <= '0;
              epoch_q <= epoch_q + EpochW'(1);
            end
          end
          gds_pkg::OP_PREP_CLEAR: begin
            unmet_q <= '0;
            abort_q <= 1'b0;
            code_q  <= '0;
            epoch_q <= '0;
          end
          gds_pkg::OP_ABORT: begin
            if (!abort_q && val_q != '0) begin
              abort_q <= 1'b1;
              code_q  <= val_q;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.fail) begin
        abort_q <= 1'b1;
        code_q  <= gds_pkg::FailCode;
        st_q    <= gds_pkg::FailCode;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      if (op_q == gds_pkg::OP_EXEC) word_status_o <= st_q;
      else word_status_o <= abort_q ? code_q : '0;
      unmet_count_o <= unmet_q;
      all_met_o     <= abort_q || (unmet_q == '0);
      aborted_o     <= abort_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.op         = op_q;
    status_o.empty      = !node_in || rel_used == '0 || end_clamp <= start_q;
    status_o.aborted    = abort_q;
    status_o.free_max   = free_rd_q == '1;
    status_o.walk_last  = (i_q + DataW'(1)) == end_clamp;
    status_o.skip       = ll_rd_q[NodeW] || req_rd_q >= fg_q;
    status_o.need_count = !(sub_rd_q < req_rd_q) && sub_rd_q < fg_q;
    status_o.unmet_full = unmet_q == '1;
    status_o.member_ok  = node_in && mem_rd_q && rel_used != '0;
    status_o.sub_max    = sub_rd_q == '1;
    status_o.uncount    = sub_rd_q < req_rd_q && sub_inc >= req_rd_q;
    status_o.unmet_zero = unmet_q == '0;
    status_o.clr_last   = clr_q == '1;
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

  `GDS_ASSERT_IMP(a_load_free, cmd_i.load_result, !status_o.out_busy, "result over untaken word")
  `GDS_ASSERT_IMP(a_req_raise, cmd_i.req_wr, fg_q > req_rd_q, "required generation not raised")
  `GDS_ASSERT(a_abort_code, !abort_q || code_q != '0, "abort set with a zero code")
  `GDS_ASSERT_IMP(a_uncount, cmd_i.unmet_dec, unmet_q != '0, "unmet count decremented at zero")

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for generation_dependency_scoreboard.
// Drives opcode words and register writes, checks each result against a typed or predicted word; needs gds_pkg.
`timescale 1ns / 1ps

module tb;

  // Opcodes 6 and 7 are no-ops in the block.
  localparam logic [2:0] OP_NOP_A = 3'd6;
  localparam logic [2:0] OP_NOP_B = 3'd7;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int OFF_CAP = 40;  // largest offset value the random phases program
  localparam int LIST_LEN = 48; // most launch-list slots programmed per phase
  localparam int DIR_ROWS = 30;
  localparam int PHASES = 8;

  typedef struct packed {
    logic [gds_pkg::DataW-1:0]  status;
    logic [gds_pkg::UnmetW-1:0] unmet;
    logic                       all_met;
    logic                       aborted;
  } result_t;

  typedef struct {
    logic [2:0]                op;
    logic [gds_pkg::NodeW-1:0] node;
    logic [gds_pkg::RcntW-1:0] slot;
    logic [gds_pkg::DataW-1:0] value;
    bit                        typed;
    result_t                   want;
  } row_t;

  typedef struct {
    logic [gds_pkg::DataW-1:0] nodes;
    logic [gds_pkg::DataW-1:0] rels;
    int                        count;
    bit                        idle;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [2:0] opcode_i = '0;
  logic [gds_pkg::NodeW-1:0] node_i = '0;
  logic [gds_pkg::RcntW-1:0] slot_i = '0;
  logic [gds_pkg::DataW-1:0] value_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [gds_pkg::DataW-1:0] cfg_data_i = '0;
  wire in_ready_o, out_valid_o, all_met_o, aborted_o, cfg_ready_o;
  wire [gds_pkg::DataW-1:0] status_o;
  wire [gds_pkg::UnmetW-1:0] unmet_count_o;

  generation_dependency_scoreboard dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the scoreboard state
  // ---------------------------------------------------------------------
  logic [10:0]     node_cnt;
  logic [12:0]     rel_cnt;
  logic [12:0]     row_off   [gds_pkg::OffDepth];
  logic [12:0]     list_ids  [gds_pkg::MaxRelations];
  bit              off_set   [gds_pkg::OffDepth];
  bit              id_set    [gds_pkg::MaxRelations];
  bit              member    [gds_pkg::MaxNodes];
  logic [gds_pkg::GenW-1:0] free_g [gds_pkg::MaxNodes];
  logic [gds_pkg::GenW-1:0] req_g  [gds_pkg::MaxNodes];
  logic [gds_pkg::GenW-1:0] sub_g  [gds_pkg::MaxNodes];
  logic [10:0]     unmet;
  bit              abort_f;
  logic [12:0]     abort_c;
  logic [gds_pkg::EpochW-1:0] epoch;

  result_t status_q[$];   // expected status words, oldest first
  int err_cnt = 0;
  bit idle_en = 1'b0;

  function automatic int nodes_used();
    return (node_cnt < gds_pkg::MaxNodes) ? node_cnt : gds_pkg::MaxNodes;
  endfunction

  function automatic int rels_used();
    return (rel_cnt < gds_pkg::MaxRelations) ? rel_cnt : gds_pkg::MaxRelations;
  endfunction

  function automatic void trip();
    abort_f = 1'b1;
    abort_c = gds_pkg::FailCode;
  endfunction

  function automatic void clear_gens();
    foreach (free_g[i]) begin
      free_g[i] = '0;
      req_g[i] = '0;
      sub_g[i] = '0;
    end
  endfunction

  // Free side: bump the node's generation and raise it in every in-range launch it feeds that is lower.
  function automatic logic [12:0] free_side(int n);
    int rel, s, e, id;
    logic [gds_pkg::GenW-1:0] fg, sb;
    bit behind;
    rel = rels_used();
    if (n >= nodes_used() || rel == 0) return '0;
    s = row_off[n];
    e = row_off[n+1];
    if (e > rel) e = rel;
    if (e <= s) return '0;
    if (abort_f) return abort_c;
    if (free_g[n] == '1) begin
      trip();
      return gds_pkg::FailCode;
    end
    fg = free_g[n] + 1;
    free_g[n] = fg;
    for (int i = s; i < e; i++) begin
      id = list_ids[i];
      if (id >= gds_pkg::MaxNodes || req_g[id] >= fg) continue;
      sb = sub_g[id];
      behind = sb < req_g[id];
      req_g[id] = fg;
      if (!behind && sb < fg) begin
        if (unmet >= 11'd2047) begin
          trip();
          return gds_pkg::FailCode;
        end
        unmet++;
      end
    end
    return '0;
  endfunction

  // Launch side: a member node submits and may catch up.
  function automatic logic [12:0] launch_side(int n);
    logic [gds_pkg::GenW-1:0] rq;
    bit behind;
    if (rels_used() == 0) return '0;
    if (abort_f) return abort_c;
    if (sub_g[n] == '1) begin
      trip();
      return gds_pkg::FailCode;
    end
    rq = req_g[n];
    behind = sub_g[n] < rq;
    sub_g[n]++;
    if (behind && sub_g[n] >= rq) begin
      if (unmet == 0) begin
        trip();
        return gds_pkg::FailCode;
      end
      unmet--;
    end
    return '0;
  endfunction

  function automatic result_t predict_status(logic [2:0] op, logic [gds_pkg::NodeW-1:0] n,
                                             logic [gds_pkg::RcntW-1:0] slot,
                                             logic [gds_pkg::DataW-1:0] val);
    result_t r;
    logic [12:0] st;
    bit failed;
    st = '0;
    failed = 1'b0;
    case (op)
      gds_pkg::OP_EXEC: begin
        st = free_side(n);
        if (st == 0 && n < nodes_used() && member[n]) st = launch_side(n);
      end
      gds_pkg::OP_RESET_RUN: begin
        clear_gens();
        unmet = '0;
        abort_f = 1'b0;
        abort_c = '0;
        if (epoch == '1) begin
          trip();
          failed = 1'b1;
        end else begin
          epoch++;
        end
      end
      gds_pkg::OP_ABORT: begin
        if (!abort_f && val != 0) begin
          abort_f = 1'b1;
          abort_c = val;
        end
      end
      gds_pkg::OP_WR_OFFSET: begin
        if (slot <= gds_pkg::MaxNodes) begin
          row_off[slot] = val;
          off_set[slot] = 1'b1;
        end
      end
      gds_pkg::OP_WR_LAUNCH: begin
        if (slot < gds_pkg::MaxRelations) begin
          list_ids[slot] = val;
          id_set[slot] = 1'b1;
          if (val < gds_pkg::MaxNodes) member[val] = 1'b1;
        end
      end
      gds_pkg::OP_PREP_CLEAR: begin
        clear_gens();
        foreach (member[i]) member[i] = 1'b0;
        unmet = '0;
        abort_f = 1'b0;
        abort_c = '0;
        epoch = '0;
      end
      default: ;
    endcase
    if (op != gds_pkg::OP_EXEC) st = failed ? gds_pkg::FailCode : (abort_f ? abort_c : '0);
    r.status = st;
    r.unmet = unmet;
    r.all_met = abort_f || unmet == 0;
    r.aborted = abort_f;
    return r;
  endfunction

  // Find a table entry that executing node n would read before it is written.
  function automatic bit find_hole(logic [gds_pkg::NodeW-1:0] n, output bit is_off,
                                   output int idx);
    int rel, s, e;
    rel = rels_used();
    is_off = 1'b0;
    idx = 0;
    if (n >= nodes_used() || rel == 0) return 1'b0;
    is_off = 1'b1;
    if (!off_set[n]) begin
      idx = n;
      return 1'b1;
    end
    if (!off_set[n+1]) begin
      idx = n + 1;
      return 1'b1;
    end
    is_off = 1'b0;
    s = row_off[n];
    e = row_off[n+1];
    if (e > rel) e = rel;
    for (int i = s; i < e; i++) begin
      if (!id_set[i]) begin
        idx = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  // Send one word; called right after a rising edge. Expectation is typed or predicted.
  task automatic send_word(logic [2:0] op, logic [gds_pkg::NodeW-1:0] n,
                           logic [gds_pkg::RcntW-1:0] slot, logic [gds_pkg::DataW-1:0] val,
                           bit typed = 1'b0, result_t want = '0);
    result_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    node_i <= n;
    slot_i <= slot;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_status(op, n, slot, val);
    status_q.push_back(typed ? want : r);
  endtask

  // Send an exec word, first filling any table entry it would read unwritten.
  task automatic send_exec(logic [gds_pkg::NodeW-1:0] n);
    bit is_off;
    int idx;
    while (find_hole(n, is_off, idx)) begin
      if (is_off)
        send_word(gds_pkg::OP_WR_OFFSET, '0, gds_pkg::RcntW'(idx),
                  gds_pkg::DataW'($urandom_range(0, OFF_CAP)));
      else
        send_word(gds_pkg::OP_WR_LAUNCH, '0, gds_pkg::RcntW'(idx),
                  gds_pkg::DataW'($urandom_range(0, 23)));
    end
    send_word(gds_pkg::OP_EXEC, n, '0, '0);
  endtask

  task automatic write_reg(gds_pkg::reg_e idx, logic [gds_pkg::DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gds_pkg::REG_NODE_COUNT) node_cnt = data[10:0];
    else rel_cnt = data;
  endtask

  // Hold the sender until every expected word has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Program a small compressed-row table over the first nodes.
  task automatic load_table(int k, int len);
    int off;
    off = 0;
    for (int i = 0; i <= k; i++) begin
      send_word(gds_pkg::OP_WR_OFFSET, '0, gds_pkg::RcntW'(i), gds_pkg::DataW'(off));
      off = off + $urandom_range(0, 3);
      if (off > OFF_CAP) off = OFF_CAP;
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_word(gds_pkg::OP_WR_LAUNCH, '0, gds_pkg::RcntW'(i),
                  gds_pkg::DataW'($urandom_range(gds_pkg::MaxNodes, 8191)));
      else
        send_word(gds_pkg::OP_WR_LAUNCH, '0, gds_pkg::RcntW'(i),
                  gds_pkg::DataW'($urandom_range(0, (k > 0) ? k - 1 : 0)));
    end
  endtask

  // One random word: mostly node executions on the programmed nodes, the rest control and noise.
  task automatic send_random(int k, int len);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 68) send_exec(gds_pkg::NodeW'($urandom_range(0, k)));
    else if (pick < 71) send_exec(gds_pkg::NodeW'($urandom()));
    else if (pick < 76)
      send_word(gds_pkg::OP_RESET_RUN, gds_pkg::NodeW'($urandom()), '0,
                gds_pkg::DataW'($urandom()));
    else if (pick < 79) send_word(gds_pkg::OP_ABORT, '0, '0, gds_pkg::DataW'($urandom()));
    else if (pick < 81) send_word(gds_pkg::OP_PREP_CLEAR, '0, gds_pkg::RcntW'($urandom()), '0);
    else if (pick < 87)
      send_word(gds_pkg::OP_WR_LAUNCH, '0, gds_pkg::RcntW'($urandom_range(0, len - 1)),
                gds_pkg::DataW'($urandom_range(0, (k > 0) ? k - 1 : 0)));
    else if (pick < 90)
      send_word(gds_pkg::OP_WR_OFFSET, '0, gds_pkg::RcntW'($urandom_range(0, k)),
                gds_pkg::DataW'($urandom_range(0, OFF_CAP)));
    else if (pick < 93)
      send_word(gds_pkg::OP_WR_OFFSET, gds_pkg::NodeW'($urandom()),
                gds_pkg::RcntW'($urandom_range(gds_pkg::MaxNodes + 1, 8191)),
                gds_pkg::DataW'($urandom()));
    else if (pick < 96)
      send_word(gds_pkg::OP_WR_LAUNCH, '0,
                gds_pkg::RcntW'($urandom_range(gds_pkg::MaxRelations, 8191)),
                gds_pkg::DataW'($urandom()));
    else
      send_word(($urandom_range(0, 1) != 0) ? OP_NOP_A : OP_NOP_B, gds_pkg::NodeW'($urandom()),
                gds_pkg::RcntW'($urandom()), gds_pkg::DataW'($urandom()));
  endtask

  // Result side: stall in random bursts while idling is enabled.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted word with the oldest expectation; watch the cycle limit.
  int cycles = 0;
  always @(posedge clk_i) begin
    result_t w;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        $error("status word with nothing expected");
        err_cnt++;
      end else begin
        w = status_q[0];
        status_q.delete(0);
        if (status_o !== w.status) begin
          $error("status: expected %0h, got %0h", w.status, status_o);
          err_cnt++;
        end
        if (unmet_count_o !== w.unmet) begin
          $error("unmet_count: expected %0d, got %0d", w.unmet, unmet_count_o);
          err_cnt++;
        end
        if (all_met_o !== w.all_met) begin
          $error("all_met: expected %0b, got %0b", w.all_met, all_met_o);
          err_cnt++;
        end
        if (aborted_o !== w.aborted) begin
          $error("aborted: expected %0b, got %0b", w.aborted, aborted_o);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  localparam result_t CLEAN = '{status: '0, unmet: '0, all_met: 1'b1, aborted: 1'b0};
  localparam result_t FAILED = '{status: gds_pkg::FailCode, unmet: '0, all_met: 1'b1,
                                 aborted: 1'b1};

  row_t dir_rows [DIR_ROWS];
  phase_t phases [PHASES];

  initial begin
    int k, len;
    node_cnt = '0;
    rel_cnt = '0;
    foreach (row_off[i]) begin
      row_off[i] = '0;
      off_set[i] = 1'b0;
    end
    foreach (list_ids[i]) begin
      list_ids[i] = '0;
      id_set[i] = 1'b0;
    end
    foreach (member[i]) member[i] = 1'b0;
    clear_gens();
    unmet = '0;
    abort_f = 1'b0;
    abort_c = '0;
    epoch = '0;

    // Directed words over a four-node table with eight relations.
    dir_rows = '{
      '{OP_NOP_B,               0,    0,    0, 1, CLEAN},
      '{gds_pkg::OP_WR_OFFSET,  0,    0,    0, 1, CLEAN},
      '{gds_pkg::OP_WR_OFFSET,  0,    1,    2, 1, CLEAN},
      '{gds_pkg::OP_WR_OFFSET,  0,    2,    3, 1, CLEAN},
      '{gds_pkg::OP_WR_OFFSET,  0,    3,    3, 1, CLEAN},
      '{gds_pkg::OP_WR_OFFSET,  0,    4, 8191, 1, CLEAN},  // end clamps to relation count
      '{gds_pkg::OP_WR_OFFSET,  0, 1024,    0, 1, CLEAN},
      '{gds_pkg::OP_WR_OFFSET,  0, 1025,    5, 1, CLEAN},  // out of range, dropped
      '{gds_pkg::OP_WR_LAUNCH,  0,    0,    1, 1, CLEAN},
      '{gds_pkg::OP_WR_LAUNCH,  0,    1,    2, 1, CLEAN},
      '{gds_pkg::OP_WR_LAUNCH,  0,    2, 8191, 1, CLEAN},  // id past the node range
      '{gds_pkg::OP_WR_LAUNCH,  0,    3,    3, 1, CLEAN},
      '{gds_pkg::OP_WR_LAUNCH,  0,    4,    0, 1, CLEAN},
      '{gds_pkg::OP_WR_LAUNCH,  0,    5,    1, 1, CLEAN},
      '{gds_pkg::OP_WR_LAUNCH,  0,    6,    2, 1, CLEAN},
      '{gds_pkg::OP_WR_LAUNCH,  0,    7,    3, 1, CLEAN},
      '{gds_pkg::OP_WR_LAUNCH,  0, 4096,    1, 1, CLEAN},  // slot past the list, dropped
      '{gds_pkg::OP_EXEC,       0,    0,    0, 0, CLEAN},
      '{gds_pkg::OP_EXEC,       1,    0,    0, 0, CLEAN},
      '{gds_pkg::OP_EXEC,       3,    0,    0, 0, CLEAN},
      '{gds_pkg::OP_EXEC,       2,    0,    0, 0, CLEAN},  // empty row
      '{gds_pkg::OP_EXEC,    1023,    0,    0, 0, CLEAN},  // beyond node count
      '{gds_pkg::OP_ABORT,      0,    0,    0, 0, CLEAN},  // zero code is ignored
      '{gds_pkg::OP_ABORT,      0,    0, 8191, 0, CLEAN},
      '{gds_pkg::OP_ABORT,      0,    0,    5, 0, CLEAN},  // first code sticks
      '{gds_pkg::OP_EXEC,       0,    0,    0, 0, CLEAN},
      '{gds_pkg::OP_RESET_RUN,  0,    0,    0, 1, CLEAN},
      '{gds_pkg::OP_PREP_CLEAR, 0,    0,    0, 1, CLEAN},
      '{gds_pkg::OP_ABORT,      0,    0, 8191, 1, FAILED},
      '{OP_NOP_A,               0,    0,    0, 1, FAILED}
    };

    // Register settings per phase, extremes included; the sixth and the last run without idling.
    phases = '{
      '{13'd0,    13'd0,    50,  1},
      '{13'h1FFF, 13'h1FFF, 120, 1},  // node count truncates to 2047
      '{13'd1024, 13'd4096, 120, 1},
      '{13'd1025, 13'd0,    60,  1},
      '{13'd16,   13'd5,    120, 1},
      '{13'd24,   13'd64,   120, 0},
      '{13'd2,    13'd1,    50,  1},
      '{13'd12,   13'd30,   120, 0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(gds_pkg::REG_NODE_COUNT, 13'd4);
    write_reg(gds_pkg::REG_RELATION_COUNT, 13'd8);
    @(posedge clk_i);
    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].node, dir_rows[i].slot, dir_rows[i].value,
                dir_rows[i].typed, dir_rows[i].want);
    drain();

    foreach (phases[p]) begin
      write_reg(gds_pkg::REG_NODE_COUNT, phases[p].nodes);
      write_reg(gds_pkg::REG_RELATION_COUNT, phases[p].rels);
      idle_en = phases[p].idle;
      @(posedge clk_i);
      k = (nodes_used() < 20) ? nodes_used() : 20;
      len = (rels_used() == 0) ? 8 : ((rels_used() < LIST_LEN) ? rels_used() : LIST_LEN);
      send_word(gds_pkg::OP_PREP_CLEAR, '0, '0, '0);
      load_table(k, len);
      for (int i = 0; i < phases[p].count; i++) begin
        // Hold off mid-phase once until the block has answered everything.
        if (p == 2 && i == 60) drain();
        send_random(k, len);
      end
      drain();
    end

    idle_en = 1'b0;
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/gds_pkg.sv
src/gds_ctrl.sv
src/gds_datapath.sv
src/generation_dependency_scoreboard.sv
bench/tb.sv
